>>> rtl/core/dmss_pkg.sv
// shared types and constants of the distance map similarity score block
package dmss_pkg;

  localparam int MAX_DIM_DEF   = 1024;
  localparam int FRAC_BITS_DEF = 4;

  localparam int DIST_W = 16;
  localparam int DIM_CFG_W = 11;
  localparam int WGT_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W = 36;
  localparam int HALF_W = 18;
  localparam int MUL_W = 33;
  localparam int SCORE_W = 16;

  localparam logic [DIM_CFG_W-1:0] ROWS_RST  = 11'd256;
  localparam logic [DIM_CFG_W-1:0] COLS_RST  = 11'd256;
  localparam logic [WGT_W-1:0]     ALPHA_RST = 16'd10000;
  localparam logic [WGT_W-1:0]     BETA_RST  = 16'd5000;

  localparam int CNT_W = 6;
  localparam int K_W = 4;
  localparam logic [CNT_W-1:0] DIV_LAST  = 6'd31;
  localparam logic [CNT_W-1:0] SQ_LAST   = 6'd3;
  localparam logic [K_W-1:0]   K_LAST    = 4'd14;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS  = 2'd0,
    CFG_COLS  = 2'd1,
    CFG_ALPHA = 2'd2,
    CFG_BETA  = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACC, OP_MA_LO, OP_MA_HI, OP_MB_LO, OP_MB_HI, OP_MRC, OP_MDEN,
    OP_DEN, OP_CMP, OP_DIV, OP_EXP_INIT, OP_T_MUL, OP_T_LOAD, OP_T_DIV,
    OP_T_ACC, OP_E_SET, OP_SQ_MUL, OP_SQ_TAKE, OP_OUT
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MA_LO, ST_MA_HI, ST_MB_LO, ST_MB_HI, ST_MRC, ST_MDEN, ST_DEN,
    ST_CMP, ST_DIV, ST_EXP_INIT, ST_T_MUL, ST_T_LOAD, ST_T_DIV, ST_T_ACC,
    ST_E_SET, ST_SQ_MUL, ST_SQ_TAKE, ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e         op;
    logic [K_W-1:0] k;
  } dmss_cmd_t;

  typedef struct packed {
    logic over;
  } dmss_sts_t;

endpackage

>>> rtl/core/dmss_datapath.sv
// datapath: config registers, pixel sums, shared multiplier, divider and exp evaluation
module dmss_datapath import dmss_pkg::*; #(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [2*DIST_W-1:0]   pix_data_i,
  input  dmss_cmd_t             cmd_i,
  output dmss_sts_t             sts_o,
  output logic [SCORE_W-1:0]    score_o
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int DEN_W  = 3 * DIM_W + 1 + FRAC_BITS;
  localparam int NUM_W  = WGT_W + SUM_W + 1;
  localparam int CMP_W  = (NUM_W + 1 > DEN_W + 4) ? NUM_W + 1 : DEN_W + 4;
  localparam int R_W    = DEN_W + 5;

  logic [DIM_CFG_W-1:0] rows_q, cols_q;
  logic [WGT_W-1:0]     alpha_q, beta_q;
  logic [SUM_W-1:0]     s1_q, s1_d, s2_q, s2_d;
  logic [NUM_W-1:0]     num_q;
  logic [DEN_W-1:0]     den_q;
  logic [R_W-1:0]       r_q, rs, dd;
  logic [31:0]          y_q;
  logic                 over_q;
  logic [MUL_W-1:0]     term_q;
  logic [SUM_W-1:0]     pos_q, neg_q, e_q;
  logic [2*MUL_W-1:0]   prod_q, prod_d;
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [SCORE_W-1:0]   score_q;
  logic [DIM_W-1:0]     rows_c, cols_c;
  logic [CMP_W-1:0]     num2, den12;
  logic                 over_now;
  logic [DIST_W-1:0]    cand, targ;
  logic [SUM_W:0]       a1, a2;
  logic [MUL_W-1:0]     rcp;
  logic [2:0]           rsh;
  logic [2*MUL_W-33:0]  quot;
  logic [31:0]          e_c;
  logic [SUM_W:0]       rnd;

  assign cand = pix_data_i[DIST_W-1:0];
  assign targ = pix_data_i[2*DIST_W-1:DIST_W];
  assign a1 = (SUM_W+1)'(s1_q) + (SUM_W+1)'(cand);
  assign a2 = (SUM_W+1)'(s2_q) + (SUM_W+1)'(targ);

  always_comb begin
    s1_d = s1_q;
    s2_d = s2_q;
    if (targ == '0) s1_d = a1[SUM_W] ? '1 : a1[SUM_W-1:0];
    if (cand == '0) s2_d = a2[SUM_W] ? '1 : a2[SUM_W-1:0];
  end

  // zero size reads as one, oversize reads as the largest size
  always_comb begin
    if (rows_q == '0) rows_c = DIM_W'(1);
    else if (32'(rows_q) > 32'(MAX_DIM)) rows_c = DIM_W'(MAX_DIM);
    else rows_c = DIM_W'(rows_q);
    if (cols_q == '0) cols_c = DIM_W'(1);
    else if (32'(cols_q) > 32'(MAX_DIM)) cols_c = DIM_W'(MAX_DIM);
    else cols_c = DIM_W'(cols_q);
  end

  assign e_c = (e_q > SUM_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : e_q[31:0];

  // ceil(2^(32+s)/k) with s = ceil(log2 k): exact floor of a 32-bit term over k
  always_comb begin
    case (cmd_i.k)
      4'd1:    begin rcp = 33'd4294967296; rsh = 3'd0; end
      4'd2:    begin rcp = 33'd4294967296; rsh = 3'd1; end
      4'd3:    begin rcp = 33'd5726623062; rsh = 3'd2; end
      4'd4:    begin rcp = 33'd4294967296; rsh = 3'd2; end
      4'd5:    begin rcp = 33'd6871947674; rsh = 3'd3; end
      4'd6:    begin rcp = 33'd5726623062; rsh = 3'd3; end
      4'd7:    begin rcp = 33'd4908534053; rsh = 3'd3; end
      4'd8:    begin rcp = 33'd4294967296; rsh = 3'd3; end
      4'd9:    begin rcp = 33'd7635497416; rsh = 3'd4; end
      4'd10:   begin rcp = 33'd6871947674; rsh = 3'd4; end
      4'd11:   begin rcp = 33'd6247225158; rsh = 3'd4; end
      4'd12:   begin rcp = 33'd5726623062; rsh = 3'd4; end
      4'd13:   begin rcp = 33'd5286113596; rsh = 3'd4; end
      4'd14:   begin rcp = 33'd4908534053; rsh = 3'd4; end
      default: begin rcp = '0; rsh = '0; end
    endcase
  end

  always_comb begin
    case (cmd_i.op)
      OP_MA_LO: begin mul_a = MUL_W'(alpha_q); mul_b = MUL_W'(s1_q[HALF_W-1:0]); end
      OP_MA_HI: begin mul_a = MUL_W'(alpha_q); mul_b = MUL_W'(s1_q[SUM_W-1:HALF_W]); end
      OP_MB_LO: begin mul_a = MUL_W'(beta_q); mul_b = MUL_W'(s2_q[HALF_W-1:0]); end
      OP_MB_HI: begin mul_a = MUL_W'(beta_q); mul_b = MUL_W'(s2_q[SUM_W-1:HALF_W]); end
      OP_MRC:   begin mul_a = MUL_W'(rows_c); mul_b = MUL_W'(cols_c); end
      OP_MDEN: begin
        mul_a = MUL_W'(prod_q[2*DIM_W-1:0]);
        mul_b = MUL_W'(rows_c) + MUL_W'(cols_c);
      end
      OP_T_MUL:  begin mul_a = term_q; mul_b = MUL_W'(y_q); end
      OP_T_DIV:  begin mul_a = term_q; mul_b = rcp; end
      OP_SQ_MUL: begin mul_a = MUL_W'(e_c); mul_b = MUL_W'(e_c); end
      default:   begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod_d = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);

  assign num2  = CMP_W'({num_q, 1'b0});
  assign den12 = (CMP_W'(den_q) << 3) + (CMP_W'(den_q) << 2);
  assign over_now = num2 >= den12;
  assign sts_o.over = over_now;

  assign rs = {r_q[R_W-2:0], 1'b0};
  assign dd = R_W'(den_q) << 4;

  assign quot = prod_q[2*MUL_W-1:32] >> rsh;

  assign rnd = (SUM_W+1)'(e_q) + (SUM_W+1)'(32'h8000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= ROWS_RST;
      cols_q  <= COLS_RST;
      alpha_q <= ALPHA_RST;
      beta_q  <= BETA_RST;
      s1_q    <= '0;
      s2_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROWS:  rows_q  <= cfg_data_i[DIM_CFG_W-1:0];
          CFG_COLS:  cols_q  <= cfg_data_i[DIM_CFG_W-1:0];
          CFG_ALPHA: alpha_q <= cfg_data_i[WGT_W-1:0];
          CFG_BETA:  beta_q  <= cfg_data_i[WGT_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_ACC) begin
        s1_q <= s1_d;
        s2_q <= s2_d;
      end else if (cmd_i.op == OP_MRC) begin
        s1_q <= '0;
        s2_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_MA_LO: prod_q <= prod_d;
      OP_MA_HI: begin prod_q <= prod_d; num_q <= NUM_W'(prod_q); end
      OP_MB_LO: begin prod_q <= prod_d; num_q <= num_q + (NUM_W'(prod_q) << HALF_W); end
      OP_MB_HI: begin prod_q <= prod_d; num_q <= num_q + NUM_W'(prod_q); end
      OP_MRC:   begin prod_q <= prod_d; num_q <= num_q + (NUM_W'(prod_q) << HALF_W); end
      OP_MDEN:  prod_q <= prod_d;
      OP_DEN:   den_q <= DEN_W'(prod_q[3*DIM_W:0]) << FRAC_BITS;
      OP_CMP: begin
        over_q <= over_now;
        r_q    <= R_W'(num2);
        y_q    <= '0;
      end
      OP_DIV: begin
        if (rs >= dd) begin
          r_q <= rs - dd;
          y_q <= {y_q[30:0], 1'b1};
        end else begin
          r_q <= rs;
          y_q <= {y_q[30:0], 1'b0};
        end
      end
      OP_EXP_INIT: begin
        term_q <= MUL_W'(64'h1_0000_0000);
        pos_q  <= SUM_W'(64'h1_0000_0000);
        neg_q  <= '0;
      end
      OP_T_MUL:  prod_q <= prod_d;
      OP_T_LOAD: term_q <= prod_q[2*MUL_W-2:32];
      OP_T_DIV:  prod_q <= prod_d;
      OP_T_ACC: begin
        term_q <= MUL_W'(quot);
        if (cmd_i.k[0]) neg_q <= neg_q + SUM_W'(quot);
        else pos_q <= pos_q + SUM_W'(quot);
      end
      OP_E_SET:   e_q <= (pos_q > neg_q) ? pos_q - neg_q : '0;
      OP_SQ_MUL:  prod_q <= prod_d;
      OP_SQ_TAKE: e_q <= SUM_W'(prod_q[63:32]);
      OP_OUT: begin
        if (over_q) score_q <= '0;
        else if (rnd[SUM_W:16] > (SUM_W-15)'(16'hFFFF)) score_q <= '1;
        else score_q <= rnd[31:16];
      end
      default: ;
    endcase
  end

  assign score_o = score_q;

endmodule

>>> rtl/core/dmss_ctrl.sv
// controller: pixel handshake, score sequencing and output valid
module dmss_ctrl import dmss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_axis_tvalid,
  output logic      s_axis_tready,
  input  logic      s_axis_tlast,
  output logic      m_axis_tvalid,
  input  logic      m_axis_tready,
  input  dmss_sts_t sts_i,
  output dmss_cmd_t cmd_o
);

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [K_W-1:0]   k_q, k_d;
  logic             vld_q, vld_d;
  logic             fire;
  logic             in_acc;

  assign s_axis_tready = state_q == ST_IDLE;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  // result register is free when empty or being drained this cycle
  assign fire = (state_q == ST_OUT) && (!vld_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    case (state_q)
      ST_IDLE:  if (in_acc && s_axis_tlast) state_d = ST_MA_LO;
      ST_MA_LO: state_d = ST_MA_HI;
      ST_MA_HI: state_d = ST_MB_LO;
      ST_MB_LO: state_d = ST_MB_HI;
      ST_MB_HI: state_d = ST_MRC;
      ST_MRC:   state_d = ST_MDEN;
      ST_MDEN:  state_d = ST_DEN;
      ST_DEN:   state_d = ST_CMP;
      ST_CMP: begin
        cnt_d   = '0;
        state_d = sts_i.over ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) state_d = ST_EXP_INIT;
      end
      ST_EXP_INIT: begin
        k_d     = K_W'(1);
        state_d = ST_T_MUL;
      end
      ST_T_MUL:  state_d = ST_T_LOAD;
      ST_T_LOAD: state_d = ST_T_DIV;
      ST_T_DIV:  state_d = ST_T_ACC;
      ST_T_ACC: begin
        k_d = k_q + 1'b1;
        state_d = (k_q == K_LAST) ? ST_E_SET : ST_T_MUL;
      end
      ST_E_SET: begin
        cnt_d   = '0;
        state_d = ST_SQ_MUL;
      end
      ST_SQ_MUL: state_d = ST_SQ_TAKE;
      ST_SQ_TAKE: begin
        cnt_d = cnt_q + 1'b1;
        state_d = (cnt_q == SQ_LAST) ? ST_OUT : ST_SQ_MUL;
      end
      ST_OUT:   if (fire) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.k = k_q;
    case (state_q)
      ST_IDLE:     cmd_o.op = in_acc ? OP_ACC : OP_NONE;
      ST_MA_LO:    cmd_o.op = OP_MA_LO;
      ST_MA_HI:    cmd_o.op = OP_MA_HI;
      ST_MB_LO:    cmd_o.op = OP_MB_LO;
      ST_MB_HI:    cmd_o.op = OP_MB_HI;
      ST_MRC:      cmd_o.op = OP_MRC;
      ST_MDEN:     cmd_o.op = OP_MDEN;
      ST_DEN:      cmd_o.op = OP_DEN;
      ST_CMP:      cmd_o.op = OP_CMP;
      ST_DIV:      cmd_o.op = OP_DIV;
      ST_EXP_INIT: cmd_o.op = OP_EXP_INIT;
      ST_T_MUL:    cmd_o.op = OP_T_MUL;
      ST_T_LOAD:   cmd_o.op = OP_T_LOAD;
      ST_T_DIV:    cmd_o.op = OP_T_DIV;
      ST_T_ACC:    cmd_o.op = OP_T_ACC;
      ST_E_SET:    cmd_o.op = OP_E_SET;
      ST_SQ_MUL:   cmd_o.op = OP_SQ_MUL;
      ST_SQ_TAKE:  cmd_o.op = OP_SQ_TAKE;
      ST_OUT:      cmd_o.op = fire ? OP_OUT : OP_NONE;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

  always_comb begin
    vld_d = vld_q;
    if (m_axis_tready) vld_d = 1'b0;
    if (fire) vld_d = 1'b1;
  end

  assign m_axis_tvalid = vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      vld_q   <= vld_d;
    end
  end

  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> state_q == ST_MA_LO)
    else $error("last pixel did not start scoring");

  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_T_ACC) |-> (k_q != '0 && k_q <= K_LAST))
    else $error("series term index out of range");

  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> cnt_q <= DIV_LAST)
    else $error("divider step count overrun");

  a_fire_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> m_axis_tvalid)
    else $error("score load did not raise valid");

endmodule

>>> rtl/core/distance_map_similarity_score.sv
// Distance map similarity score: pixel pairs are accepted one per cycle while idle and summed.
// After the pixel marked last the block stops taking pixels for the score pass: setup, the
// bit-serial normalizing divide, series setup, 14 series terms, where the divide of every term
// by its index is one multiply by a fixed reciprocal, forming the exponential, 4 squarings and
// loading the output register, or only setup and the output load when the distance is large
// enough that the score is zero. The output load waits while the previous score is still
// unread. Pixel input resumes once the score is loaded into the output register.
module distance_map_similarity_score import dmss_pkg::*; #(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [2*DIST_W-1:0]   s_axis_tdata,  // candidate_distance, target_distance
  input  logic                  s_axis_tlast,  // last_pixel
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [SCORE_W-1:0]    m_axis_tdata   // score
);

  dmss_cmd_t cmd;
  dmss_sts_t sts;

  dmss_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  dmss_datapath #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_data_i (s_axis_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .score_o    (m_axis_tdata)
  );

endmodule

>>> tb/sv/distance_map_similarity_score_test.sv
// testbench for the distance map similarity score block
module distance_map_similarity_score_test;
  import dmss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned SUM_SAT = (64'd1 << 36) - 1;

  // score prediction and the queue of scores still owed by the block
  class score_board;
    longint unsigned rows, cols, alpha, beta;
    longint unsigned sum_tz, sum_cz;
    bit [SCORE_W-1:0] pending_scores[$];
    int errors;

    function new();
      rows = ROWS_RST;
      cols = COLS_RST;
      alpha = ALPHA_RST;
      beta = BETA_RST;
      sum_tz = 0;
      sum_cz = 0;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, longint unsigned val);
      case (idx)
        CFG_ROWS: rows = val & 11'h7ff;
        CFG_COLS: cols = val & 11'h7ff;
        CFG_ALPHA: alpha = val & 16'hffff;
        CFG_BETA: beta = val & 16'hffff;
        default: ;
      endcase
    endfunction

    function longint unsigned fix_dim(longint unsigned d);
      if (d == 0) return 1;
      if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
      return d;
    endfunction

    function bit [SCORE_W-1:0] similarity();
      longint unsigned r, c, den, num, q, rem, y, pos, neg, term, e;
      r = fix_dim(rows);
      c = fix_dim(cols);
      den = (r * c * (r + c)) << FRAC_BITS_DEF;
      num = 2 * (alpha * sum_tz + beta * sum_cz);
      q = num / den;
      rem = num % den;
      if (q >= 12) return 0;
      y = q;
      for (int i = 0; i < 28; i++) begin
        rem = rem << 1;
        y = y << 1;
        if (rem >= den) begin
          rem -= den;
          y |= 1;
        end
      end
      pos = 64'd1 << 32;
      neg = 0;
      term = 64'd1 << 32;
      for (int k = 1; k <= 14; k++) begin
        term = ((term * y) >> 32) / k;
        if (k % 2) neg += term;
        else pos += term;
      end
      e = (pos > neg) ? pos - neg : 0;
      for (int i = 0; i < 4; i++) begin
        if (e > 64'hffff_ffff) e = 64'hffff_ffff;
        e = (e * e) >> 32;
      end
      e = (e + 64'h8000) >> 16;
      return (e > 64'hffff) ? 16'hffff : e[15:0];
    endfunction

    function void note_pixel(bit [15:0] cand, bit [15:0] targ, bit last);
      if (targ == 0) sum_tz = (sum_tz + cand > SUM_SAT) ? SUM_SAT : sum_tz + cand;
      if (cand == 0) sum_cz = (sum_cz + targ > SUM_SAT) ? SUM_SAT : sum_cz + targ;
      if (last) begin
        pending_scores.insert(pending_scores.size(), similarity());
        sum_tz = 0;
        sum_cz = 0;
      end
    endfunction

    function void check_score(bit [SCORE_W-1:0] got);
      bit [SCORE_W-1:0] want;
      if (pending_scores.size() == 0) begin
        $error("score: none expected, actual %0d", got);
        errors++;
        return;
      end
      want = pending_scores[0];
      pending_scores.delete(0);
      if (want != got) begin
        $error("score: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [2*DIST_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [SCORE_W-1:0] m_axis_tdata;

  score_board sb = new();
  bit calm = 1'b0;

  distance_map_similarity_score dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #100ms;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: random stalls except during the calm stretch
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_score(m_axis_tdata);
    m_axis_tready <= calm || ($urandom_range(99) >= 21);
  end

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    sb.write_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // valid stays up between back to back requests and drops only while idling
  task automatic send_pixel(logic [15:0] cand, logic [15:0] targ, logic last);
    while (!calm && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {targ, cand};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pixel(cand, targ, last);
  endtask

  // drain owed scores, then let the score pass settle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_scores.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
  endtask

  // mostly zero-rich pixels so both sums grow; small values keep scores nonzero
  task automatic random_image(int npix);
    logic [15:0] c, t;
    for (int i = 0; i < npix; i++) begin
      c = ($urandom_range(2) == 0) ? 16'd0 :
          ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(40));
      t = ($urandom_range(2) == 0) ? 16'd0 :
          ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(40));
      send_pixel(c, t, i == npix - 1);
    end
  endtask

  initial begin
    int sent;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: reset config, extremes, both sums zero, saturation
    send_pixel(16'd0, 16'd0, 1'b1);
    send_pixel(16'd5, 16'd0, 1'b0);
    send_pixel(16'd0, 16'd7, 1'b1);
    send_pixel(16'hffff, 16'd0, 1'b1);
    send_pixel(16'd0, 16'hffff, 1'b1);
    send_pixel(16'hffff, 16'hffff, 1'b1);
    send_pixel(16'h5555, 16'haaaa, 1'b0);
    send_pixel(16'haaaa, 16'h5555, 1'b1);
    settle();
    write_reg(CFG_ROWS, 16'd0);
    write_reg(CFG_COLS, 16'd2047);
    write_reg(CFG_ALPHA, 16'hffff);
    write_reg(CFG_BETA, 16'd0);
    send_pixel(16'd1, 16'd0, 1'b1);
    send_pixel(16'd0, 16'hffff, 1'b1);
    for (int i = 0; i < 4; i++) send_pixel(16'hffff, 16'd0, i == 3);
    settle();
    write_reg(CFG_ROWS, 16'd1);
    write_reg(CFG_COLS, 16'd1);
    write_reg(CFG_ALPHA, 16'd0);
    write_reg(CFG_BETA, 16'hffff);
    send_pixel(16'd0, 16'd1, 1'b1);
    send_pixel(16'd0, 16'd3, 1'b1);
    send_pixel(16'd0, 16'hffff, 1'b1);
    settle();
    sent = 0;
    for (int phase = 0; phase < 8; phase++) begin
      calm = (phase == 3);
      write_reg(CFG_ROWS, 16'($urandom_range(1, 40)));
      write_reg(CFG_COLS, 16'($urandom_range(1, 40)));
      write_reg(CFG_ALPHA, (phase == 5) ? 16'hffff : 16'($urandom_range(0, 3000)));
      write_reg(CFG_BETA, (phase == 6) ? 16'd0 : 16'($urandom_range(0, 3000)));
      for (int n = 0; n < 245; ) begin
        int len;
        len = $urandom_range(1, 30);
        random_image(len);
        n += len;
        sent += len;
      end
      settle();
    end
    calm = 1'b0;
    if (sb.errors == 0 && sb.pending_scores.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
